// ----- src/odometry_map_scale_estimator_assert.svh -----
// Assertion macros shared by the estimator RTL.
// Each macro expects clk and arst_n in scope.
`ifndef ODOMETRY_MAP_SCALE_ESTIMATOR_ASSERT_SVH
`define ODOMETRY_MAP_SCALE_ESTIMATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define OMSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define OMSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/omse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omse_pkg
// Types and constants of the odometry map scale estimator.
// ----------------------------------------------------------------------------
package omse_pkg;

	localparam int COORD_W = 24;
	localparam int DIST_W  = 25;
	localparam int SQ_W    = 50;
	localparam int SCALE_W = 24;
	localparam int DTD_W   = 24;
	localparam int FRAC_W  = 16;
	localparam int NUM_W   = DIST_W + FRAC_W;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [DIST_W-1:0]  MIN_DIST        = 25'd41;
	localparam logic [SCALE_W-1:0] SCALE_ONE       = 24'd65536;
	localparam logic [SCALE_W-1:0] SCALE_MAX       = 24'hFFFFFF;
	localparam logic [DTD_W-1:0]   DTD_RESET       = 24'd4096;
	localparam logic [2:0]         RUNAWAY_FACTOR  = 3'd5;

	// register index, taken from paddr[ADDR_W-1:2]
	localparam logic [ADDR_W-3:0]  REG_DTD = '0;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [2:0][COORD_W-1:0]   vec3_t;

	typedef enum logic [1:0] {
		KIND_CAM_START = 2'd0,
		KIND_ODOM      = 2'd1,
		KIND_CHECK     = 2'd2,
		KIND_CAM_END   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK_GO,
		S_CHK_RUN,
		S_CAM_GO,
		S_CAM_RUN,
		S_ODO_GO,
		S_ODO_RUN,
		S_DIV_GO,
		S_DIV_RUN,
		S_FIN
	} top_state_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_SQUARE,
		DS_ROOT
	} dist_state_t;

	typedef struct packed {
		logic start;
		logic three_d;
	} dist_req_t;

endpackage

// ----- src/omse_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omse_pose_if / omse_status_if
// Valid/ready channels for pose items and status results.
// ----------------------------------------------------------------------------
interface omse_pose_if;
	import omse_pkg::*;

	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	coord_t      x_pos;
	coord_t      y_pos;
	coord_t      z_pos;

	modport source (output valid, kind, x_pos, y_pos, z_pos, input ready);
	modport sink (input valid, kind, x_pos, y_pos, z_pos, output ready);
endinterface

interface omse_status_if;
	import omse_pkg::*;

	logic                valid;
	logic                ready;
	logic                ready_res;
	logic                camera_position_known;
	logic [DIST_W-1:0]   distance_driven;
	logic [SCALE_W-1:0]  scale_value;
	logic                scale_fresh;

	modport source (output valid, ready_res, camera_position_known, distance_driven,
		scale_value, scale_fresh, input ready);
	modport sink (input valid, ready_res, camera_position_known, distance_driven,
		scale_value, scale_fresh, output ready);
endinterface

// ----- src/odometry_map_scale_estimator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_map_scale_estimator
// Tracks odometry and camera travel and estimates a Q8.16 map scale.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-----------------------------------------
//  pose     | in  | valid / ready  | kind, x_pos, y_pos, z_pos
//  status   | out | valid / ready  | ready_res, camera_position_known,
//           |     |                | distance_driven, scale_value, scale_fresh
//  apb      | in  | psel / penable | distance_to_drive at byte address 0
//
// One item at a time. Camera start, odometry and an ignored camera end go
// straight to S_FIN. A check runs a 2D distance in the one bit-serial
// distance unit: a shift-add square per axis, then a sqrt. A camera end while
// ready runs two 3D distances and, if both reach MIN_DIST, a divide. One
// result register: a new item is taken while it waits; the item then holds at
// its end until the register is free. No clearing pass.
// ----------------------------------------------------------------------------
module odometry_map_scale_estimator (
	input  logic                           clk,
	input  logic                           arst_n,
	omse_pose_if.sink                      pose,
	omse_status_if.source                  status,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [omse_pkg::ADDR_W-1:0]    paddr,
	input  logic [omse_pkg::DATA_W-1:0]    pwdata,
	output logic [omse_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);
	import omse_pkg::*;

	top_state_t         state_q, state_d;

	logic [DTD_W-1:0]   dtd_q;
	vec3_t              cam_q;
	vec3_t              odo_start_q;
	vec3_t              odo_cur_q;
	vec3_t              pt_q;
	logic               awaiting_q;
	logic               cam_known_q;
	logic               odo_en_q;
	logic               ready_q;
	logic [SCALE_W-1:0] scale_q;
	logic               updated_q;
	logic [DIST_W-1:0]  last_dist_q;
	logic [DIST_W-1:0]  dm_q;
	logic [DIST_W-1:0]  dodo_q;

	logic               out_valid_q;
	logic               out_ready_q;
	logic               out_known_q;
	logic [DIST_W-1:0]  out_dist_q;
	logic [SCALE_W-1:0] out_scale_q;
	logic               out_updated_q;

	logic               in_xfer;
	logic               slot_free;
	logic               use_cam;
	logic               big_enough;
	logic               cfg_wr;
	logic [DTD_W+2:0]   runaway;
	vec3_t              in_pt;
	vec3_t              dist_a;
	vec3_t              dist_b;
	dist_req_t          dist_req;
	logic               dist_done;
	logic [DIST_W-1:0]  dist_val;
	logic               div_start;
	logic               div_done;
	logic [SCALE_W-1:0] div_quot;

	assign in_xfer    = pose.valid && pose.ready;
	assign slot_free  = !out_valid_q || status.ready;
	assign in_pt      = {pose.z_pos, pose.y_pos, pose.x_pos};
	assign use_cam    = (state_q == S_CAM_GO) || (state_q == S_CAM_RUN);
	assign dist_a     = use_cam ? cam_q : odo_start_q;
	assign dist_b     = use_cam ? pt_q : odo_cur_q;
	assign big_enough = (dm_q >= MIN_DIST) && (dist_val >= MIN_DIST);
	assign runaway    = (DTD_W+3)'(dtd_q) * (DTD_W+3)'(RUNAWAY_FACTOR);

	// APB: zero wait states, one register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[ADDR_W-1:2] == REG_DTD) ? DATA_W'(dtd_q) : '0;

	always_comb begin
		state_d          = state_q;
		pose.ready       = 1'b0;
		dist_req.start   = 1'b0;
		dist_req.three_d = 1'b1;
		div_start        = 1'b0;
		case (state_q)
			S_IDLE: begin
				pose.ready = 1'b1;
				if (pose.valid) begin
					case (pose.kind)
						KIND_CAM_START: state_d = S_FIN;
						KIND_ODOM:      state_d = S_FIN;
						KIND_CHECK:     state_d = S_CHK_GO;
						KIND_CAM_END:   state_d = ready_q ? S_CAM_GO : S_FIN;
						default:        state_d = S_FIN;
					endcase
				end
			end
			S_CHK_GO: begin
				dist_req.start   = 1'b1;
				dist_req.three_d = 1'b0;
				state_d          = S_CHK_RUN;
			end
			S_CHK_RUN: begin
				dist_req.three_d = 1'b0;
				if (dist_done) state_d = S_FIN;
			end
			S_CAM_GO: begin
				dist_req.start = 1'b1;
				state_d        = S_CAM_RUN;
			end
			S_CAM_RUN: begin
				if (dist_done) state_d = S_ODO_GO;
			end
			S_ODO_GO: begin
				dist_req.start = 1'b1;
				state_d        = S_ODO_RUN;
			end
			S_ODO_RUN: begin
				if (dist_done) state_d = big_enough ? S_DIV_GO : S_FIN;
			end
			S_DIV_GO: begin
				div_start = 1'b1;
				state_d   = S_DIV_RUN;
			end
			S_DIV_RUN: begin
				if (div_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dtd_q       <= DTD_RESET;
			cam_q       <= '0;
			odo_start_q <= '0;
			odo_cur_q   <= '0;
			awaiting_q  <= 1'b1;
			cam_known_q <= 1'b0;
			odo_en_q    <= 1'b0;
			ready_q     <= 1'b0;
			scale_q     <= SCALE_ONE;
			updated_q   <= 1'b0;
			last_dist_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[ADDR_W-1:2] == REG_DTD)) dtd_q <= pwdata[DTD_W-1:0];

			if (in_xfer) begin
				case (pose.kind)
					KIND_CAM_START: begin
						cam_q       <= in_pt;
						cam_known_q <= 1'b1;
						odo_en_q    <= 1'b1;
					end
					KIND_ODOM: begin
						if (odo_en_q) begin
							odo_cur_q  <= in_pt;
							if (awaiting_q) odo_start_q <= in_pt;
							awaiting_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end

			if ((state_q == S_CHK_RUN) && dist_done) begin
				last_dist_q <= dist_val;
				if ((DTD_W+3)'(dist_val) > runaway) begin
					cam_known_q <= 1'b0;
					awaiting_q  <= 1'b1;
				end else if ((DTD_W+3)'(dist_val) >= (DTD_W+3)'(dtd_q)) begin
					ready_q  <= 1'b1;
					odo_en_q <= 1'b0;
				end
			end

			// too short a move leaves the scale alone but still counts as an update
			if ((state_q == S_ODO_RUN) && dist_done && !big_enough) updated_q <= 1'b1;

			if ((state_q == S_DIV_RUN) && div_done) begin
				scale_q   <= div_quot;
				updated_q <= 1'b1;
			end

			if ((state_q == S_FIN) && slot_free) out_valid_q <= 1'b1;
			else if (status.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) pt_q <= in_pt;
		if ((state_q == S_CAM_RUN) && dist_done) dm_q <= dist_val;
		if ((state_q == S_ODO_RUN) && dist_done) dodo_q <= dist_val;
		if ((state_q == S_FIN) && slot_free) begin
			out_ready_q   <= ready_q;
			out_known_q   <= cam_known_q;
			out_dist_q    <= last_dist_q;
			out_scale_q   <= scale_q;
			out_updated_q <= updated_q;
		end
	end

	assign status.valid                 = out_valid_q;
	assign status.ready_res             = out_ready_q;
	assign status.camera_position_known = out_known_q;
	assign status.distance_driven       = out_dist_q;
	assign status.scale_value           = out_scale_q;
	assign status.scale_fresh           = out_updated_q;

	omse_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dist_req),
		.a      (dist_a),
		.b      (dist_b),
		.done   (dist_done),
		.len    (dist_val)
	);

	omse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (dodo_q),
		.den    (dm_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	`include "odometry_map_scale_estimator_assert.svh"

	`OMSE_ASSERT_NOW(a_dist_done_waiting, dist_done, (state_q == S_CHK_RUN) || (state_q == S_CAM_RUN) || (state_q == S_ODO_RUN), "distance result with no wait state")
	`OMSE_ASSERT_NEXT(a_ready_sticky, ready_q, ready_q, "ready flag cleared")
	`OMSE_ASSERT_NOW(a_scale_from_div, scale_q != $past(scale_q), $past(div_done), "scale changed without a divide")

endmodule

// ----- src/omse_dist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omse_dist
// Bit-serial Euclidean distance: shift-add squares, then restoring sqrt.
// ----------------------------------------------------------------------------
module omse_dist (
	input  logic                           clk,
	input  logic                           arst_n,
	input  omse_pkg::dist_req_t            req,
	input  omse_pkg::vec3_t                a,
	input  omse_pkg::vec3_t                b,
	output logic                           done,
	output logic [omse_pkg::DIST_W-1:0]    len
);
	import omse_pkg::*;

	localparam int CNT_W = $clog2(DIST_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIST_W - 1);

	dist_state_t       state_q, state_d;
	logic [1:0]        dim_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              three_d_q;
	logic [DIST_W-1:0] mag_q;
	logic [SQ_W-1:0]   mcand_q;
	logic [SQ_W-1:0]   acc_q;
	logic [SQ_W-1:0]   root_q;
	logic [SQ_W-1:0]   bitw_q;
	logic              done_q;

	logic [1:0]        sel_dim;
	logic [DIST_W-1:0] diff;
	logic [DIST_W-1:0] mag_new;
	logic [SQ_W-1:0]   acc_n;
	logic [SQ_W:0]     trial;
	logic              fits;
	logic              last_dim;
	logic              cnt_end;

	always_comb begin
		sel_dim  = (state_q == DS_IDLE) ? 2'd0 : dim_q + 2'd1;
		diff     = {a[sel_dim][COORD_W-1], a[sel_dim]} - {b[sel_dim][COORD_W-1], b[sel_dim]};
		mag_new  = diff[DIST_W-1] ? (~diff + 1'b1) : diff;
		acc_n    = acc_q + (mag_q[0] ? mcand_q : '0);
		trial    = {1'b0, root_q} + {1'b0, bitw_q};
		fits     = {1'b0, acc_q} >= trial;
		last_dim = three_d_q ? (dim_q == 2'd2) : (dim_q == 2'd1);
		cnt_end  = (cnt_q == CNT_LAST);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			DS_IDLE: begin
				if (req.start) state_d = DS_SQUARE;
			end
			DS_SQUARE: begin
				if (cnt_end && last_dim) state_d = DS_ROOT;
			end
			DS_ROOT: begin
				if (cnt_end) state_d = DS_IDLE;
			end
			default: state_d = DS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DS_ROOT) && cnt_end;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DS_IDLE: begin
				if (req.start) begin
					dim_q     <= 2'd0;
					cnt_q     <= '0;
					three_d_q <= req.three_d;
					mag_q     <= mag_new;
					mcand_q   <= SQ_W'(mag_new);
					acc_q     <= '0;
				end
			end
			DS_SQUARE: begin
				acc_q <= acc_n;
				if (cnt_end) begin
					cnt_q <= '0;
					if (last_dim) begin
						root_q <= '0;
						bitw_q <= SQ_W'(1) << (SQ_W - 2);
					end else begin
						dim_q   <= sel_dim;
						mag_q   <= mag_new;
						mcand_q <= SQ_W'(mag_new);
					end
				end else begin
					cnt_q   <= cnt_q + 1'b1;
					mag_q   <= mag_q >> 1;
					mcand_q <= mcand_q << 1;
				end
			end
			DS_ROOT: begin
				if (fits) begin
					acc_q  <= acc_q - trial[SQ_W-1:0];
					root_q <= (root_q >> 1) + bitw_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bitw_q <= bitw_q >> 2;
				cnt_q  <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign len  = root_q[DIST_W-1:0];

endmodule

// ----- src/omse_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omse_div
// Restoring divider, one quotient bit per cycle, saturating Q8.16 result.
// ----------------------------------------------------------------------------
module omse_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [omse_pkg::DIST_W-1:0]    num,
	input  logic [omse_pkg::DIST_W-1:0]    den,
	output logic                           done,
	output logic [omse_pkg::SCALE_W-1:0]   quot
);
	import omse_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]   num_q;
	logic [DIST_W-1:0]  den_q;
	logic [DIST_W-1:0]  rem_q;
	logic [SCALE_W-1:0] quot_q;
	logic               ovf_q;

	logic [DIST_W:0]    rem_t;
	logic [DIST_W:0]    rem_sub;
	logic               ge;

	always_comb begin
		rem_t   = {rem_q, num_q[NUM_W-1]};
		rem_sub = rem_t - {1'b0, den_q};
		ge      = rem_t >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (start) busy_q <= 1'b1;
			else if (busy_q && (cnt_q == CNT_LAST)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {num, FRAC_W'(0)};
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sub[DIST_W-1:0] : rem_t[DIST_W-1:0];
			num_q  <= num_q << 1;
			quot_q <= {quot_q[SCALE_W-2:0], ge};
			// any 1 leaving the top means the quotient exceeds the scale range
			ovf_q  <= ovf_q | quot_q[SCALE_W-1];
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	assign done = done_q;
	assign quot = ovf_q ? SCALE_MAX : quot_q;

endmodule

// ----- tb/omse_scale_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omse_scale_checker
// Watches the pose, status and APB traffic of the map scale estimator. It
// tracks the estimator state, works out the status word that each accepted
// pose item must produce and compares the status transfers in order.
// ----------------------------------------------------------------------------
module omse_scale_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	omse_pose_if                          pose,
	omse_status_if                        status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [omse_pkg::ADDR_W-1:0]   paddr,
	input  logic [omse_pkg::DATA_W-1:0]   pwdata,
	output int                            fails,
	output int                            outstanding,
	output int                            checked,
	output int                            rescaled
);
	import omse_pkg::*;

	typedef struct packed {
		logic               ready_res;
		logic               cam_known;
		logic [DIST_W-1:0]  travel;
		logic [SCALE_W-1:0] scale;
		logic               updated;
	} status_word_t;

	status_word_t        status_due[$];

	vec3_t               cam_origin;
	vec3_t               odo_first;
	vec3_t               odo_now;
	logic                first_pending;
	logic                cam_known;
	logic                odo_on;
	logic                ready_seen;
	logic                upd_seen;
	logic [SCALE_W-1:0]  scale_now;
	logic [DIST_W-1:0]   travel_last;
	logic [DTD_W-1:0]    drive_target;

	// largest r with r*r <= v, one result bit per step
	function automatic logic [DIST_W-1:0] floor_root(logic [63:0] v);
		logic [DIST_W-1:0] r;
		logic [DIST_W-1:0] t;
		r = '0;
		for (int b = DIST_W - 1; b >= 0; b--) begin
			t = r | (DIST_W'(1) << b);
			if (64'(t) * 64'(t) <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [DIST_W-1:0] gap_len(vec3_t a, vec3_t b, bit with_z);
		logic [63:0] sum;
		longint      d;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			if (i < 2 || with_z) begin
				d = longint'(coord_t'(a[i])) - longint'(coord_t'(b[i]));
				sum += 64'(d * d);
			end
		end
		return floor_root(sum);
	endfunction

	function automatic status_word_t advance_estimate(kind_t k, vec3_t p);
		logic [DIST_W-1:0] cam_len;
		logic [DIST_W-1:0] odo_len;
		logic [63:0]       ratio;
		status_word_t      w;
		case (k)
		KIND_CAM_START: begin
			cam_origin = p;
			cam_known  = 1'b1;
			odo_on     = 1'b1;
		end
		KIND_ODOM: begin
			if (odo_on) begin
				odo_now = p;
				if (first_pending)
					odo_first = p;
				first_pending = 1'b0;
			end
		end
		KIND_CHECK: begin
			travel_last = gap_len(odo_first, odo_now, 1'b0);
			// runaway: drop the camera point and restart the odometry baseline
			if (64'(travel_last) > 64'(drive_target) * RUNAWAY_FACTOR) begin
				cam_known     = 1'b0;
				first_pending = 1'b1;
			end else if (travel_last >= drive_target) begin
				ready_seen = 1'b1;
				odo_on     = 1'b0;
			end
		end
		KIND_CAM_END: begin
			if (ready_seen) begin
				cam_len = gap_len(cam_origin, p, 1'b1);
				odo_len = gap_len(odo_first, odo_now, 1'b1);
				if (cam_len >= MIN_DIST && odo_len >= MIN_DIST) begin
					ratio = (64'(odo_len) << FRAC_W) / 64'(cam_len);
					scale_now = (ratio > 64'(SCALE_MAX)) ? SCALE_MAX : ratio[SCALE_W-1:0];
					rescaled++;
				end
				upd_seen = 1'b1;
			end
		end
		default: ;
		endcase
		w.ready_res = ready_seen;
		w.cam_known = cam_known;
		w.travel    = travel_last;
		w.scale     = scale_now;
		w.updated   = upd_seen;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		status_word_t got;
		status_word_t want;
		if (!arst_n) begin
			status_due.delete();
			cam_origin    = '0;
			odo_first     = '0;
			odo_now       = '0;
			first_pending = 1'b1;
			cam_known     = 1'b0;
			odo_on        = 1'b0;
			ready_seen    = 1'b0;
			upd_seen      = 1'b0;
			scale_now     = SCALE_ONE;
			travel_last   = '0;
			drive_target  = DTD_RESET;
			outstanding  <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_DTD)
				drive_target = pwdata[DTD_W-1:0];
			if (pose.valid && pose.ready)
				status_due.push_back(advance_estimate(kind_t'(pose.kind),
					{pose.z_pos, pose.y_pos, pose.x_pos}));
			if (status.valid && status.ready) begin
				got = {status.ready_res, status.camera_position_known,
					status.distance_driven, status.scale_value, status.scale_fresh};
				if (status_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: status transfer with nothing pending", $realtime);
				end else begin
					want = status_due.pop_front();
					checked++;
					if (got != want) begin
						fails++;
						if (fails <= 10)
							$display({"%0t: status mismatch (exp/got) ready %0b/%0b known %0b/%0b",
								" dist %0d/%0d scale %0d/%0d updated %0b/%0b"}, $realtime,
								want.ready_res, got.ready_res, want.cam_known, got.cam_known,
								want.travel, got.travel, want.scale, got.scale,
								want.updated, got.updated);
					end
				end
			end
			outstanding <= status_due.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the odometry map scale estimator: a directed opening, then
// drive/measure episodes with random content under several travel targets,
// with random idling on both channels. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb_top;
	import omse_pkg::*;

	localparam longint COORD_HI = 8388607;
	localparam longint COORD_LO = -8388608;
	localparam int     N_PHASES = 7;
	localparam int     PHASE_ITEMS = 235;
	localparam logic [ADDR_W-1:0] DTD_ADDR   = {REG_DTD, 2'b00};
	// next register slot is unmapped, writes there must not land
	localparam logic [ADDR_W-1:0] SPARE_ADDR = DTD_ADDR + 3'd4;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	int                 check_fails;
	int                 pending_cnt;
	int                 checked_cnt;
	int                 rescaled_cnt;
	int                 items_sent;
	int                 tx_gap_pct;
	int                 rx_stall_pct;
	int                 rx_hold;
	longint             drive_target;
	int unsigned        phase_target [N_PHASES];

	omse_pose_if   pose ();
	omse_status_if status ();

	always #5 clk = ~clk;

	odometry_map_scale_estimator u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pose    (pose),
		.status  (status),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	omse_scale_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.pose        (pose),
		.status      (status),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.fails       (check_fails),
		.outstanding (pending_cnt),
		.checked     (checked_cnt),
		.rescaled    (rescaled_cnt)
	);

	// status back-pressure: random bursts with ready held low
	always @(posedge clk) begin
		if (!arst_n || rx_stall_pct == 0) begin
			status.ready <= arst_n;
			rx_hold <= 0;
		end else if (rx_hold != 0) begin
			status.ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if ($urandom_range(0, 99) < rx_stall_pct) begin
			status.ready <= 1'b0;
			rx_hold <= $urandom_range(0, 14);
		end else begin
			status.ready <= 1'b1;
		end
	end

	function automatic coord_t clip(longint v);
		if (v > COORD_HI)
			return coord_t'(COORD_HI);
		if (v < COORD_LO)
			return coord_t'(COORD_LO);
		return coord_t'(v);
	endfunction

	function automatic longint any_coord();
		return longint'(coord_t'($urandom));
	endfunction

	function automatic longint near_coord();
		return longint'($urandom_range(0, 2000000)) - 1000000;
	endfunction

	// leaves valid high after the transfer so back-to-back items need no toggle
	task automatic send_item(kind_t k, longint x, longint y, longint z);
		if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			pose.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		pose.valid <= 1'b1;
		pose.kind  <= k;
		pose.x_pos <= clip(x);
		pose.y_pos <= clip(y);
		pose.z_pos <= clip(z);
		@(posedge clk);
		while (!pose.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic settle();
		pose.valid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// camera start, odometry legs around the target, checks, camera end; or 1..4 random items
	task automatic run_episode();
		longint ox, oy, oz, dx, dy, reach, cx, cy, cz, mag;
		int     legs;
		bit     corner;
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 4))
				send_item(kind_t'($urandom_range(0, 3)), any_coord(), any_coord(), any_coord());
			return;
		end
		cx = near_coord();
		cy = near_coord();
		cz = near_coord();
		send_item(KIND_CAM_START, cx, cy, cz);
		corner = ($urandom_range(0, 9) == 0);
		ox = corner ? COORD_LO : near_coord();
		oy = corner ? COORD_LO : near_coord();
		oz = near_coord();
		send_item(KIND_ODOM, ox, oy, oz);
		legs = $urandom_range(1, 3);
		for (int i = 0; i < legs; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				// axis aligned, right at the target
				reach = drive_target + $urandom_range(0, 2) - 1;
				if (reach < 0)
					reach = 0;
				dx = reach;
				dy = 0;
			end else begin
				reach = drive_target * $urandom_range(0, 65) / 10;
				dx = $urandom_range(0, 32'(reach));
				dy = reach - dx;
			end
			if ($urandom_range(0, 1))
				dx = -dx;
			if ($urandom_range(0, 1))
				dy = -dy;
			send_item(KIND_ODOM, ox + dx, oy + dy, oz + $urandom_range(0, 200) - 100);
			if ($urandom_range(0, 3) == 0)
				send_item(KIND_CHECK, any_coord(), any_coord(), any_coord());
		end
		if (corner)
			send_item(KIND_ODOM, COORD_HI, COORD_HI, any_coord());
		if ($urandom_range(0, 4) == 0)
			send_item(KIND_CAM_END, cx + near_coord(), cy, cz);
		repeat ($urandom_range(1, 2))
			send_item(KIND_CHECK, any_coord(), any_coord(), any_coord());
		if ($urandom_range(0, 3) == 0)
			send_item(KIND_ODOM, near_coord(), near_coord(), near_coord());
		case ($urandom_range(0, 9))
		0, 1: send_item(KIND_CAM_END, cx + $urandom_range(0, 23), cy - $urandom_range(0, 23),
			cz + $urandom_range(0, 23));
		2: send_item(KIND_CAM_END, any_coord(), any_coord(), any_coord());
		default: begin
			mag = 1 << $urandom_range(4, 18);
			send_item(KIND_CAM_END, cx + $urandom_range(0, 32'(2 * mag)) - mag,
				cy + $urandom_range(0, 32'(2 * mag)) - mag,
				cz + $urandom_range(0, 32'(2 * mag)) - mag);
		end
		endcase
	endtask

	initial begin
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		pose.valid  <= 1'b0;
		pose.kind   <= KIND_CHECK;
		pose.x_pos  <= '0;
		pose.y_pos  <= '0;
		pose.z_pos  <= '0;
		items_sent   = 0;
		tx_gap_pct   = 20;
		rx_stall_pct = 10;
		drive_target = DTD_RESET;
		phase_target = '{0, 24'hFFFFFF, 41, DTD_RESET, $urandom_range(1000, 60000),
			$urandom_range(0, 24'hFFFFFF), 3000};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening, reset target of 1.0 m
		send_item(KIND_CHECK, 0, 0, 0);
		send_item(KIND_ODOM, COORD_HI, COORD_LO, COORD_HI);
		send_item(KIND_CAM_END, COORD_LO, COORD_HI, -1);
		send_item(KIND_CAM_START, COORD_HI, COORD_LO, COORD_HI);
		send_item(KIND_ODOM, 0, 0, 0);
		send_item(KIND_ODOM, 1000, 1000, -5);
		send_item(KIND_CHECK, 0, 0, 0);
		send_item(KIND_ODOM, 30000, 0, 5);
		send_item(KIND_CHECK, COORD_HI, COORD_HI, COORD_HI);
		send_item(KIND_ODOM, 100, 100, 0);
		send_item(KIND_ODOM, 4196, 100, 7);
		send_item(KIND_CHECK, COORD_LO, COORD_LO, COORD_LO);
		send_item(KIND_CHECK, 0, 0, 0);
		send_item(KIND_ODOM, COORD_LO, COORD_HI, 0);
		send_item(KIND_CAM_END, COORD_HI - 20, COORD_LO, COORD_HI);
		send_item(KIND_CAM_START, 0, 0, 0);
		send_item(KIND_ODOM, 12100, 100, 0);
		send_item(KIND_CAM_END, 41, 0, 0);
		send_item(KIND_CAM_END, COORD_LO, COORD_LO, COORD_LO);
		send_item(KIND_ODOM, 110, 100, 0);
		send_item(KIND_CAM_END, 4096, 0, 0);
		send_item(KIND_ODOM, 4196, 100, 4096);
		send_item(KIND_CAM_END, 0, 4096, 0);
		send_item(KIND_CHECK, -1, -1, -1);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			write_reg(DTD_ADDR, {8'($urandom), 24'(phase_target[ph])});
			drive_target = phase_target[ph];
			if (ph % 2 == 1)
				write_reg(SPARE_ADDR, $urandom);
			if (ph == N_PHASES - 1) begin
				tx_gap_pct   = 0;
				rx_stall_pct = 0;
			end else begin
				tx_gap_pct   = 15 * $urandom_range(0, 2);
				rx_stall_pct = 8 * $urandom_range(0, 2);
			end
			for (int goal = items_sent + PHASE_ITEMS; items_sent < goal; )
				run_episode();
		end

		settle();
		repeat (400) @(posedge clk);
		$display("Sent %0d pose items under %0d travel targets plus the reset one;",
			items_sent, N_PHASES);
		$display("compared %0d status transfers, %0d of them with a new scale ratio.",
			checked_cnt, rescaled_cnt);
		if (check_fails == 0 && pending_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
